// ----- rtl/periodic_timer_bank_macros.svh -----
// Assertion macros for the periodic timer bank.
// Used by the top level only; no other dependencies.
`ifndef PERIODIC_TIMER_BANK_MACROS_SVH
`define PERIODIC_TIMER_BANK_MACROS_SVH

`ifndef SYNTHESIS
`define PTB_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("periodic_timer_bank assertion failed");
`define PTB_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("periodic_timer_bank assertion failed");
`else
`define PTB_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define PTB_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ----- rtl/ptb_pkg.sv -----
// Shared types and codes of the periodic timer bank.
// No dependencies.
`default_nettype none

package ptb_pkg;

  localparam int OP_W      = 2;
  localparam int PERIOD_W  = 32;
  localparam int TAG_W     = 5;
  localparam int KIND_W    = 2;
  localparam int DEF_SLOTS = 16;

  localparam logic [OP_W-1:0] OP_TICK = 2'd0;
  localparam logic [OP_W-1:0] OP_ADD  = 2'd1;
  localparam logic [OP_W-1:0] OP_DEL  = 2'd2;
  localparam logic [OP_W-1:0] OP_RSVD = 2'd3;

  localparam logic [KIND_W-1:0] KIND_ADD = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DEL = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EXP = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [PERIOD_W-1:0] interval;
    logic [TAG_W-1:0]    target;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic pend_v;
  } back_stat_t;

endpackage

`default_nettype wire

// ----- rtl/ptb_if.sv -----
// Valid/ready channel interfaces of the periodic timer bank.
// Depends on ptb_pkg.
`default_nettype none

interface ptb_in_if
  import ptb_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     command;
  logic [PERIOD_W-1:0] interval_ticks;
  logic [TAG_W-1:0]    target_id;

  modport source (output valid, command, interval_ticks, target_id, input ready);
  modport sink   (input valid, command, interval_ticks, target_id, output ready);
endinterface

interface ptb_out_if
  import ptb_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [TAG_W-1:0]  timer_tag;
  logic              status;
  logic              last;

  modport source (output valid, kind, timer_tag, status, last, input ready);
  modport sink   (input valid, kind, timer_tag, status, last, output ready);
endinterface

`default_nettype wire

// ----- rtl/ptb_front.sv -----
// Front end: accepts input beats, drops unused commands, queues the rest.
// Depends on ptb_pkg and ptb_if.
`default_nettype none

module ptb_front
  import ptb_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  ptb_in_if.sink     in_ch,
  output cmd_t       q_cmd,
  output logic       q_valid,
  input  wire logic  q_pop
);

  localparam int QDEPTH = 2;
  localparam int QP_W   = $clog2(QDEPTH);
  localparam int QC_W   = $clog2(QDEPTH + 1);

  cmd_t            q_mem [QDEPTH];
  logic [QP_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QP_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QC_W-1:0] cnt_r, cnt_nxt;
  logic            push;
  logic            pop;

  assign in_ch.ready = (cnt_r != QC_W'(QDEPTH));
  assign push        = in_ch.valid && in_ch.ready && (in_ch.command != OP_RSVD);
  assign q_valid     = (cnt_r != '0);
  assign pop         = q_pop && q_valid;
  assign q_cmd       = q_mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= '{op: in_ch.command, interval: in_ch.interval_ticks,
                           target: in_ch.target_id};
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ptb_back.sv -----
// Back end: scans the slot memories one slot per cycle for each command
// bar stalls; drives the result register. Depends on ptb_pkg, ptb_if.
`default_nettype none

module ptb_back
  import ptb_pkg::*;
#(
  parameter int SLOTS = DEF_SLOTS,
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  localparam int CNT_W = $clog2(SLOTS + 1)
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire cmd_t    q_cmd,
  input  wire logic    q_valid,
  output logic         q_pop,
  ptb_out_if.source    out_ch,
  output back_stat_t   stat,
  output logic [CNT_W-1:0] act_cnt
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [PERIOD_W-1:0] mem_per [SLOTS];
  logic [PERIOD_W-1:0] mem_rem [SLOTS];
  logic [TAG_W-1:0]    mem_tag [SLOTS];
  logic [PERIOD_W-1:0] per_q, rem_q;
  logic [TAG_W-1:0]    tag_q;

  logic [1:0]          state_r, state_nxt;
  cmd_t                cmd_r, cmd_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [SLOTS-1:0]    valid_r, valid_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                add_ok_r, add_ok_nxt;
  logic [TAG_W-1:0]    add_tag_r, add_tag_nxt;
  logic                pend_v_r, pend_v_nxt;
  logic [TAG_W-1:0]    pend_tag_r, pend_tag_nxt;
  logic                out_v_r, out_v_nxt;
  logic [KIND_W-1:0]   out_kind_r, out_kind_nxt;
  logic [TAG_W-1:0]    out_tag_r, out_tag_nxt;
  logic                out_stat_r, out_stat_nxt;
  logic                out_last_r, out_last_nxt;
  logic                out_load;

  logic                out_free;
  logic                slot_v;
  logic                is_last_idx;
  logic                expire;
  logic [PERIOD_W-1:0] rem_new;
  logic                add_hit;
  logic                scan_end;
  logic                stall;
  logic                adv;
  logic                rd_en;
  logic [IDX_W-1:0]    rd_addr;

  assign out_free    = !out_v_r || out_ch.ready;
  assign slot_v      = valid_r[idx_r];
  assign is_last_idx = (idx_r == IDX_W'(SLOTS - 1));
  assign expire      = (cmd_r.op == OP_TICK) && slot_v && (rem_q <= PERIOD_W'(1));
  assign rem_new     = expire ? per_q : rem_q - 1'b1;
  assign add_hit     = (cmd_r.op == OP_ADD) && !slot_v;
  assign scan_end    = is_last_idx || add_hit;
  assign stall       = expire && pend_v_r && !out_free;
  assign adv         = (state_r == ST_SCAN) && !stall;
  assign q_pop       = (state_r == ST_IDLE) && q_valid;
  assign rd_en       = q_pop || (adv && !scan_end);
  assign rd_addr     = (state_r == ST_IDLE) ? '0 : idx_r + 1'b1;

  always_ff @(posedge clk) begin
    if (adv && (cmd_r.op == OP_TICK) && slot_v) begin
      mem_rem[idx_r] <= rem_new;
    end
    if (adv && add_hit) begin
      mem_per[idx_r] <= cmd_r.interval;
      mem_rem[idx_r] <= cmd_r.interval;
      mem_tag[idx_r] <= TAG_W'(cnt_r);
    end
    if (rd_en) begin
      per_q <= mem_per[rd_addr];
      rem_q <= mem_rem[rd_addr];
      tag_q <= mem_tag[rd_addr];
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cmd_nxt      = cmd_r;
    idx_nxt      = idx_r;
    valid_nxt    = valid_r;
    cnt_nxt      = cnt_r;
    add_ok_nxt   = add_ok_r;
    add_tag_nxt  = add_tag_r;
    pend_v_nxt   = pend_v_r;
    pend_tag_nxt = pend_tag_r;
    out_load     = 1'b0;
    out_kind_nxt = out_kind_r;
    out_tag_nxt  = out_tag_r;
    out_stat_nxt = out_stat_r;
    out_last_nxt = out_last_r;

    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          cmd_nxt    = q_cmd;
          idx_nxt    = '0;
          add_ok_nxt = 1'b0;
          state_nxt  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (adv) begin
          if (expire) begin
            if (pend_v_r) begin
              out_load     = 1'b1;
              out_kind_nxt = KIND_EXP;
              out_tag_nxt  = pend_tag_r;
              out_stat_nxt = 1'b0;
              out_last_nxt = 1'b0;
            end
            pend_v_nxt   = 1'b1;
            pend_tag_nxt = tag_q;
          end
          if (add_hit) begin
            valid_nxt[idx_r] = 1'b1;
            cnt_nxt          = cnt_r + 1'b1;
            add_ok_nxt       = 1'b1;
            add_tag_nxt      = TAG_W'(cnt_r);
          end
          if ((cmd_r.op == OP_DEL) && slot_v && (tag_q == cmd_r.target)) begin
            valid_nxt[idx_r] = 1'b0;
            if (cnt_r != '0) begin
              cnt_nxt = cnt_r - 1'b1;
            end
          end
          if (scan_end) begin
            state_nxt = ST_FIN;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      ST_FIN: begin
        case (cmd_r.op)
          OP_TICK: begin
            if (!pend_v_r) begin
              state_nxt = ST_IDLE;
            end else if (out_free) begin
              out_load     = 1'b1;
              out_kind_nxt = KIND_EXP;
              out_tag_nxt  = pend_tag_r;
              out_stat_nxt = 1'b0;
              out_last_nxt = 1'b1;
              pend_v_nxt   = 1'b0;
              state_nxt    = ST_IDLE;
            end
          end
          OP_ADD: begin
            if (out_free) begin
              out_load     = 1'b1;
              out_kind_nxt = KIND_ADD;
              out_tag_nxt  = add_ok_r ? add_tag_r : '0;
              out_stat_nxt = !add_ok_r;
              out_last_nxt = 1'b1;
              state_nxt    = ST_IDLE;
            end
          end
          default: begin
            if (out_free) begin
              out_load     = 1'b1;
              out_kind_nxt = KIND_DEL;
              out_tag_nxt  = cmd_r.target;
              out_stat_nxt = 1'b0;
              out_last_nxt = 1'b1;
              state_nxt    = ST_IDLE;
            end
          end
        endcase
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    out_v_nxt = out_load || (out_v_r && !out_ch.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      valid_r  <= '0;
      cnt_r    <= '0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      valid_r  <= valid_nxt;
      cnt_r    <= cnt_nxt;
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    idx_r      <= idx_nxt;
    add_ok_r   <= add_ok_nxt;
    add_tag_r  <= add_tag_nxt;
    pend_tag_r <= pend_tag_nxt;
    out_kind_r <= out_kind_nxt;
    out_tag_r  <= out_tag_nxt;
    out_stat_r <= out_stat_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_ch.valid     = out_v_r;
  assign out_ch.kind      = out_kind_r;
  assign out_ch.timer_tag = out_tag_r;
  assign out_ch.status    = out_stat_r;
  assign out_ch.last      = out_last_r;

  assign stat.busy   = (state_r != ST_IDLE);
  assign stat.pend_v = pend_v_r;
  assign act_cnt     = cnt_r;

endmodule

`default_nettype wire

// ----- rtl/periodic_timer_bank.sv -----
// Top level of the periodic timer bank: front queue plus slot scan engine.
// Depends on ptb_pkg, ptb_if, ptb_front, ptb_back and the macros header.
//
// Each accepted command (tick, add, delete) enters a two-entry queue and is
// then carried out by a scan through the slot memories (one read and one
// write port each) that visits one slot per cycle while no beat waits on a
// stalled output. An add stops the scan at the first free slot. A tick
// yields one expiry beat per firing slot in slot order, the final one marked
// last; a tick with no expiry yields no beat. Add and delete each yield
// exactly one beat. Command value 3 is accepted and dropped. No clearing
// pass runs after reset.
`default_nettype none
`include "periodic_timer_bank_macros.svh"

module periodic_timer_bank
  import ptb_pkg::*;
#(
  parameter int SLOTS = DEF_SLOTS
) (
  input  wire logic clk,
  input  wire logic rst_n,
  ptb_in_if.sink    in_ch,
  ptb_out_if.source out_ch
);

  localparam int CNT_W = $clog2(SLOTS + 1);

  cmd_t             q_cmd;
  logic             q_valid;
  logic             q_pop;
  back_stat_t       stat;
  logic [CNT_W-1:0] act_cnt;

  ptb_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_cmd   (q_cmd),
    .q_valid (q_valid),
    .q_pop   (q_pop)
  );

  ptb_back #(
    .SLOTS (SLOTS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_cmd   (q_cmd),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .out_ch  (out_ch),
    .stat    (stat),
    .act_cnt (act_cnt)
  );

  `PTB_ASSERT_IMP(a_cnt_bound, clk, rst_n, 1'b1, act_cnt <= CNT_W'(SLOTS))
  `PTB_ASSERT_IMP(a_pend_idle, clk, rst_n, !stat.busy, !stat.pend_v)
  `PTB_ASSERT_IMP(a_reply_last, clk, rst_n, out_ch.valid && (out_ch.kind != KIND_EXP), out_ch.last)
  `PTB_ASSERT_IMP(a_full_add, clk, rst_n, out_ch.valid && out_ch.status, out_ch.kind == KIND_ADD)

endmodule

`default_nettype wire
